// File: hw/rtl/leaf_bitmap_with_rewind_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the leaf bitmap
// Concurrent checks that are clocked on i_clk and held off while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef LEAF_BITMAP_WITH_REWIND_ASSERT_SVH
`define LEAF_BITMAP_WITH_REWIND_ASSERT_SVH

`ifndef SYNTHESIS

// The condition holds at every clock edge.
`define LBR_ASSERT(label, cond) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("leaf bitmap assertion failed");

// The antecedent implies the consequent in the same cycle.
`define LBR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("leaf bitmap assertion failed");

// The antecedent implies the consequent in the next cycle.
`define LBR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("leaf bitmap assertion failed");

`else

`define LBR_ASSERT(label, cond)
`define LBR_ASSERT_IMP(label, ante, cons)
`define LBR_ASSERT_NXT(label, ante, cons)

`endif

`endif

// File: hw/rtl/lbr_pkg.sv
// ----------------------------------------------------------------------------
// lbr_pkg
// Shared constants, types and helpers of the leaf bitmap with rewind.
// ----------------------------------------------------------------------------
package lbr_pkg;

    localparam int LEAF_CAPACITY = 4096;
    localparam int IDX_W         = 12;
    localparam int CNT_W         = 13;
    localparam int STORE_BYTES   = (LEAF_CAPACITY + 7) / 8;
    localparam int BYTE_ADDR_W   = $clog2(STORE_BYTES);

    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 24;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_REMOVE   = 2'd1,
        OP_CONTAINS = 2'd2,
        OP_REWIND   = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_RMW,
        S_WIPE,
        S_READ
    } t_state;

    typedef struct packed {
        logic                   we;
        logic [BYTE_ADDR_W-1:0] waddr;
        logic [7:0]             wdata;
        logic                   re;
        logic [BYTE_ADDR_W-1:0] raddr;
    } t_mem_req;

    // Leaf 0 of a byte is its most significant bit.
    function automatic logic [7:0] bit_mask(input logic [2:0] pos);
        bit_mask = 8'h80 >> pos;
    endfunction

endpackage

// File: hw/rtl/lbr_ram.sv
// ----------------------------------------------------------------------------
// lbr_ram
// Simple dual-port synchronous RAM with one write and one registered read port.
// ----------------------------------------------------------------------------
module lbr_ram #(
    parameter int ADDR_W = 9,
    parameter int DATA_W = 8
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] r_mem [2**ADDR_W];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

// File: hw/rtl/lbr_ctrl.sv
// ----------------------------------------------------------------------------
// lbr_ctrl
// Sequencer of the leaf bitmap: read-modify-write of one byte per operation,
// byte-wise wipe for rewinds, clearing pass after reset, high-water mark and
// the output register.
// ----------------------------------------------------------------------------
`include "leaf_bitmap_with_rewind_assert.svh"

module lbr_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lbr_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [lbr_pkg::S_TUSER_W-1:0]   s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lbr_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output lbr_pkg::t_mem_req               o_mem_req,
    input  logic [7:0]                      i_rd_data
);
    import lbr_pkg::*;

    t_state                 r_state, n_state;
    t_op                    r_op, n_op;
    logic [IDX_W-1:0]       r_idx, n_idx;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic                   r_clr, n_clr;
    logic                   r_err, n_err;
    logic [BYTE_ADDR_W-1:0] r_last, n_last;
    logic [BYTE_ADDR_W-1:0] r_wa, n_wa;
    logic [CNT_W-1:0]       r_mark, n_mark;
    logic                   r_ovld, n_ovld;
    logic                   r_present, n_present;
    logic [7:0]             r_byte, n_byte;
    logic [CNT_W-1:0]       r_omark, n_omark;
    logic                   r_oerr, n_oerr;

    t_op                    in_op;
    logic [IDX_W-1:0]       in_idx;
    logic [CNT_W-1:0]       in_cnt;
    logic                   in_clr;
    logic [CNT_W-1:0]       mark_m1;
    logic [CNT_W-1:0]       idx_ext;
    logic                   idx_bad;
    logic [7:0]             mask;
    logic [7:0]             new_byte;
    logic [BYTE_ADDR_W-1:0] first_byte;
    logic                   out_free;

    assign in_op      = t_op'(s_tuser);
    assign in_idx     = s_tdata[IDX_W-1:0];
    assign in_cnt     = s_tdata[IDX_W +: CNT_W];
    // Only a rewind that lands below the mark has anything to clear.
    assign in_clr     = (in_op == OP_REWIND) && (in_cnt < r_mark);
    assign mark_m1    = r_mark - CNT_W'(1);
    assign idx_ext    = {1'b0, r_idx};
    assign idx_bad    = idx_ext >= CNT_W'(LEAF_CAPACITY);
    assign mask       = bit_mask(r_idx[2:0]);
    assign first_byte = r_cnt[3 +: BYTE_ADDR_W];
    assign out_free   = !r_ovld || m_tready;

    always_comb begin
        unique case (r_op)
            OP_ADD:    new_byte = i_rd_data | mask;
            OP_REMOVE: new_byte = i_rd_data & ~mask;
            default:   new_byte = i_rd_data;
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_INIT: begin
                if (r_wa == BYTE_ADDR_W'(STORE_BYTES - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_state = S_RMW;
                end
            end
            S_RMW: begin
                if (r_clr) begin
                    n_state = (first_byte == r_last) ? S_READ : S_WIPE;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_WIPE: begin
                if (r_wa == r_last) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_RMW;
            end
        endcase
    end

    // Datapath, memory requests and handshake.
    always_comb begin
        n_op      = r_op;
        n_idx     = r_idx;
        n_cnt     = r_cnt;
        n_clr     = r_clr;
        n_err     = r_err;
        n_last    = r_last;
        n_wa      = r_wa;
        n_mark    = r_mark;
        n_ovld    = r_ovld && !m_tready;
        n_present = r_present;
        n_byte    = r_byte;
        n_omark   = r_omark;
        n_oerr    = r_oerr;
        o_mem_req = '0;
        s_tready  = (r_state == S_IDLE);

        unique case (r_state)
            S_INIT: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_wa;
                o_mem_req.wdata = 8'h00;
                n_wa            = r_wa + BYTE_ADDR_W'(1);
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    n_op   = in_op;
                    n_idx  = in_idx;
                    n_cnt  = in_cnt;
                    n_clr  = in_clr;
                    n_last = mark_m1[3 +: BYTE_ADDR_W];
                    if (in_op == OP_REWIND) begin
                        n_err = in_cnt > CNT_W'(LEAF_CAPACITY);
                    end else begin
                        n_err = {1'b0, in_idx} >= CNT_W'(LEAF_CAPACITY);
                    end
                    o_mem_req.re    = 1'b1;
                    o_mem_req.raddr = in_clr ? in_cnt[3 +: BYTE_ADDR_W]
                                             : in_idx[3 +: BYTE_ADDR_W];
                end
            end
            S_RMW: begin
                if (r_clr) begin
                    // Keep the leaves below the count in the first byte only.
                    o_mem_req.we    = 1'b1;
                    o_mem_req.waddr = first_byte;
                    o_mem_req.wdata = i_rd_data & ~(8'hff >> r_cnt[2:0]);
                    n_wa            = first_byte + BYTE_ADDR_W'(1);
                    n_clr           = 1'b0;
                    n_mark          = r_cnt;
                end else if (out_free) begin
                    o_mem_req.we    = !r_err && ((r_op == OP_ADD) || (r_op == OP_REMOVE));
                    o_mem_req.waddr = r_idx[3 +: BYTE_ADDR_W];
                    o_mem_req.wdata = new_byte;
                    if (!r_err) begin
                        if (r_op == OP_REWIND) begin
                            n_mark = r_cnt;
                        end else if ((r_op == OP_ADD) && (idx_ext >= r_mark)) begin
                            n_mark = idx_ext + CNT_W'(1);
                        end
                    end
                    n_ovld    = 1'b1;
                    n_present = !idx_bad && ((new_byte & mask) != 8'h00);
                    n_byte    = idx_bad ? 8'h00 : new_byte;
                    n_omark   = n_mark;
                    n_oerr    = r_err;
                end
            end
            S_WIPE: begin
                // Every leaf at or above the mark is already clear, so whole bytes go.
                o_mem_req.we    = 1'b1;
                o_mem_req.waddr = r_wa;
                o_mem_req.wdata = 8'h00;
                n_wa            = r_wa + BYTE_ADDR_W'(1);
            end
            S_READ: begin
                o_mem_req.re    = 1'b1;
                o_mem_req.raddr = r_idx[3 +: BYTE_ADDR_W];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_wa    <= '0;
            r_mark  <= '0;
            r_ovld  <= 1'b0;
            r_clr   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wa    <= n_wa;
            r_mark  <= n_mark;
            r_ovld  <= n_ovld;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_idx     <= n_idx;
        r_cnt     <= n_cnt;
        r_err     <= n_err;
        r_last    <= n_last;
        r_present <= n_present;
        r_byte    <= n_byte;
        r_omark   <= n_omark;
        r_oerr    <= n_oerr;
    end

    assign m_tvalid = r_ovld;
    assign m_tdata  = {2'b00, r_omark, r_byte, r_present};
    assign m_tuser  = r_oerr;

    `LBR_ASSERT(a_mark_in_range, r_mark <= CNT_W'(LEAF_CAPACITY))
    `LBR_ASSERT_IMP(a_no_read_on_write, o_mem_req.we, !o_mem_req.re)
    `LBR_ASSERT_NXT(a_accept_to_rmw, s_tvalid && s_tready, r_state == S_RMW)
    `LBR_ASSERT_IMP(a_wipe_in_range, r_state == S_WIPE, r_wa <= r_last)

endmodule

// File: hw/rtl/leaf_bitmap_with_rewind.sv
// ----------------------------------------------------------------------------
// leaf_bitmap_with_rewind
// Leaf presence bitmap, one bit per leaf in a byte-wide RAM, with a high-water
// mark and rewind.
//
//  Channel  Dir  tdata (low bit up)                      tuser
//  s_*      in   leaf_index[11:0], leaf_count[24:12]     op[1:0]
//  m_*      out  present[0], byte_value[8:1],            range_error
//                next_leaf[21:9]
//
// Add, remove and contains read the byte, then modify it, write it back (add
// and remove only) and load the output register. A rewind that lands below
// the mark makes one RAM write per byte of the cleared range, then re-reads
// the reported byte; any other rewind only reads and reports the byte. After
// reset a clearing pass writes all 512 bytes, one a cycle, with s_tready low.
// A stalled m_* beat holds the block in its modify step.
// ----------------------------------------------------------------------------
module leaf_bitmap_with_rewind (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [lbr_pkg::S_TDATA_W-1:0]   s_tdata,   // leaf_index, leaf_count
    input  logic [lbr_pkg::S_TUSER_W-1:0]   s_tuser,   // op
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [lbr_pkg::M_TDATA_W-1:0]   m_tdata,   // present, byte_value, next_leaf
    output logic                            m_tuser    // range_error
);
    import lbr_pkg::*;

    t_mem_req   mem_req;
    logic [7:0] rd_data;

    lbr_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .o_mem_req (mem_req),
        .i_rd_data (rd_data)
    );

    lbr_ram #(
        .ADDR_W (BYTE_ADDR_W),
        .DATA_W (8)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_req.we),
        .i_waddr (mem_req.waddr),
        .i_wdata (mem_req.wdata),
        .i_re    (mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (rd_data)
    );

endmodule
